// ===== rtl/palette_nearest_colour_distance_macros.svh =====
// ---------------------------------------------------------------------------
// palette_nearest_colour_distance_macros
// assertion macros for the palette distance block
// ---------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOUR_DISTANCE_MACROS_SVH
`define PALETTE_NEAREST_COLOUR_DISTANCE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PNCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the following cycle
`define PNCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pncd_pkg.sv =====
// ---------------------------------------------------------------------------
// pncd_pkg
// shared types and constants for the palette nearest colour distance block
// ---------------------------------------------------------------------------
package pncd_pkg;

  localparam logic [1:0] FUNC_CLEAR     = 2'd0;
  localparam logic [1:0] FUNC_ADD_QUERY = 2'd1;
  localparam logic [1:0] FUNC_ADD_REF   = 2'd2;
  localparam logic [1:0] FUNC_COMPUTE   = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_QUERY  = 2'd1;
  localparam logic [1:0] STATUS_NO_REF    = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

  localparam int unsigned ChromaWeight = 49;
  localparam int unsigned D2Width      = 24;
  localparam int unsigned RootWidth    = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIST,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start_query;
    logic start_ref;
    logic fetch;
    logic eval;
    logic root_start;
    logic root_step;
    logic accum;
    logic div_start;
    logic div_step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic ref_last;
    logic query_last;
    logic root_done;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/pncd_ctrl.sv =====
// ---------------------------------------------------------------------------
// pncd_ctrl
// sequencer for the query/reference walk, root and mean division
// ---------------------------------------------------------------------------
module pncd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  logic           out_taken_i,
  input  pncd_pkg::stat_t stat_i,
  output pncd_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           out_valid_o
);
  import pncd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (go_i) begin
          cmd_o.start_query = 1'b1;
          cmd_o.start_ref   = 1'b1;
          state_d           = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_DIST;
      end
      ST_DIST: begin
        cmd_o.eval = 1'b1;
        if (stat_i.ref_last) begin
          cmd_o.root_start = 1'b1;
          state_d          = ST_ROOT;
        end else begin
          cmd_o.fetch = 1'b1;
        end
      end
      ST_ROOT: begin
        if (stat_i.root_done) begin
          cmd_o.accum = 1'b1;
          if (stat_i.query_last) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            cmd_o.start_ref = 1'b1;
            state_d         = ST_FETCH;
          end
        end else begin
          cmd_o.root_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_taken_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pncd_datapath.sv =====
// ---------------------------------------------------------------------------
// pncd_datapath
// palette memories, distance unit, serial root, serial divider
// ---------------------------------------------------------------------------
module pncd_datapath #(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_query_i,
  input  logic            wr_ref_i,
  input  logic [23:0]     colour_i,
  input  logic [$clog2(PALETTE_DEPTH+1)-1:0] query_count_i,
  input  logic [$clog2(PALETTE_DEPTH+1)-1:0] ref_count_i,
  input  pncd_pkg::cmd_t  cmd_i,
  output pncd_pkg::stat_t stat_o,
  output logic [15:0]     mean_o
);
  import pncd_pkg::*;

  localparam int unsigned CntW  = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned AddrW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned SumW  = RootWidth + CntW;
  localparam int unsigned NumW  = SumW + 8;
  localparam int unsigned RootSteps = D2Width / 2;

  logic [23:0] query_mem [PALETTE_DEPTH];
  logic [23:0] ref_mem   [PALETTE_DEPTH];
  logic [23:0] query_rd_q, ref_rd_q;

  logic [CntW-1:0] qi_q, rj_q;
  logic [D2Width-1:0] best_q;
  logic first_q;

  // palette writes and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_query_i) begin
      query_mem[query_count_i[AddrW-1:0]] <= colour_i;
    end
    if (wr_ref_i) begin
      ref_mem[ref_count_i[AddrW-1:0]] <= colour_i;
    end
    if (cmd_i.fetch) begin
      query_rd_q <= query_mem[qi_q[AddrW-1:0]];
      ref_rd_q   <= ref_mem[rj_q[AddrW-1:0]];
    end
  end

  // weighted distance
  logic [7:0] dl, da, db;
  logic [15:0] dl2;
  logic [16:0] ab2;
  logic [D2Width-1:0] d2;

  always_comb begin
    dl  = (query_rd_q[23:16] > ref_rd_q[23:16]) ? query_rd_q[23:16] - ref_rd_q[23:16]
                                                : ref_rd_q[23:16] - query_rd_q[23:16];
    da  = (query_rd_q[15:8] > ref_rd_q[15:8]) ? query_rd_q[15:8] - ref_rd_q[15:8]
                                              : ref_rd_q[15:8] - query_rd_q[15:8];
    db  = (query_rd_q[7:0] > ref_rd_q[7:0]) ? query_rd_q[7:0] - ref_rd_q[7:0]
                                            : ref_rd_q[7:0] - query_rd_q[7:0];
    dl2 = dl * dl;
    ab2 = 17'(da) * 17'(da) + 17'(db) * 17'(db);
    d2  = D2Width'(dl2) + D2Width'(ab2) * D2Width'(ChromaWeight);
  end

  // serial square root, two bits per step
  logic [D2Width-1:0] rem_q, rem_d;
  logic [RootWidth-1:0] root_q, root_d;
  logic [D2Width-1:0] rad_q;
  logic [$clog2(RootSteps+1)-1:0] rcnt_q;
  logic [RootWidth+1:0] trial;
  logic [RootWidth+2:0] part;

  always_comb begin
    part   = {rem_q[RootWidth:0], rad_q[D2Width-1 -: 2]};
    trial  = {root_q, 2'b01};
    rem_d  = rem_q;
    root_d = {root_q[RootWidth-2:0], 1'b0};
    if (part >= {1'b0, trial}) begin
      rem_d  = D2Width'(part - {1'b0, trial});
      root_d = {root_q[RootWidth-2:0], 1'b1};
    end else begin
      rem_d  = D2Width'(part);
    end
  end

  // serial divider, restoring
  logic [NumW-1:0] num_q;
  logic [CntW:0]   drem_q;
  logic [CntW:0]   dshift;
  logic [$clog2(NumW+1)-1:0] dcnt_q;
  logic [SumW-1:0] sum_q;

  assign dshift = {drem_q[CntW-1:0], num_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qi_q    <= '0;
      rj_q    <= '0;
      first_q <= 1'b0;
      rcnt_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      if (cmd_i.start_query) begin
        qi_q <= '0;
      end else if (cmd_i.accum) begin
        qi_q <= qi_q + 1'b1;
      end
      if (cmd_i.start_ref) begin
        rj_q    <= '0;
        first_q <= 1'b1;
      end else if (cmd_i.fetch) begin
        rj_q <= rj_q + 1'b1;
      end
      if (cmd_i.eval) begin
        first_q <= 1'b0;
      end
      if (cmd_i.root_start) begin
        rcnt_q <= '0;
      end else if (cmd_i.root_step) begin
        rcnt_q <= rcnt_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && (first_q || d2 < best_q)) begin
      best_q <= d2;
    end
    if (cmd_i.root_start) begin
      rad_q  <= (first_q || d2 < best_q) ? d2 : best_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[D2Width-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
    if (cmd_i.start_query) begin
      sum_q <= '0;
    end else if (cmd_i.accum) begin
      sum_q <= sum_q + SumW'(root_q);
    end
    if (cmd_i.div_start) begin
      num_q  <= {sum_q + SumW'(root_q), 8'h00};
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dshift >= {1'b0, query_count_i}) begin
        drem_q <= dshift - {1'b0, query_count_i};
        num_q  <= {num_q[NumW-2:0], 1'b1};
      end else begin
        drem_q <= dshift;
        num_q  <= {num_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign stat_o.ref_last   = (rj_q == ref_count_i);
  assign stat_o.query_last = (qi_q == query_count_i - 1'b1);
  assign stat_o.root_done  = (rcnt_q == ($clog2(RootSteps+1))'(RootSteps));
  assign stat_o.div_done   = (dcnt_q == ($clog2(NumW+1))'(NumW));
  assign mean_o = (|num_q[NumW-1:16]) ? 16'hFFFF : num_q[15:0];

endmodule

// ===== rtl/palette_nearest_colour_distance.sv =====
// ---------------------------------------------------------------------------
// palette_nearest_colour_distance
// mean nearest weighted colour distance between two palettes
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid_i in_ready_o func/chan_l/a/b_i   | sink
//  out     | out_valid_o out_ready_i mean_distance/status_o | source
//
//  clear and append items complete as they are taken; they leave the block idle
//  compute walks every query/reference pair, keeping the nearest reference per query,
//  then takes a serial root per query and a restoring serial divide for the mean
//  a compute with an error status shows its result the cycle after it is taken
//  reset clears counts and the overflow flag; palette contents need no clear
//  the result is held on the output until taken; no new item meanwhile
module palette_nearest_colour_distance #(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  chan_l_i,
  input  logic [7:0]  chan_a_i,
  input  logic [7:0]  chan_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] mean_distance_o,
  output logic [1:0]  status_o
);
  import pncd_pkg::*;

  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);

  logic [CntW-1:0] qcnt_q, rcnt_q;
  logic ovf_q;
  logic [1:0] status_q;
  logic err_q;
  logic busy, busy_core, core_valid, accept;
  cmd_t cmd;
  stat_t stat;
  logic [15:0] mean;
  logic go, wr_q, wr_r;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;
  assign go         = accept && (func_i == FUNC_COMPUTE);
  assign wr_q = accept && (func_i == FUNC_ADD_QUERY) && (qcnt_q < CntW'(PALETTE_DEPTH));
  assign wr_r = accept && (func_i == FUNC_ADD_REF) && (rcnt_q < CntW'(PALETTE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q   <= '0;
      rcnt_q   <= '0;
      ovf_q    <= 1'b0;
      status_q <= STATUS_OK;
      err_q    <= 1'b0;
    end else begin
      if (accept && func_i == FUNC_CLEAR) begin
        qcnt_q <= '0;
        rcnt_q <= '0;
        ovf_q  <= 1'b0;
      end
      if (wr_q) begin
        qcnt_q <= qcnt_q + 1'b1;
      end
      if (wr_r) begin
        rcnt_q <= rcnt_q + 1'b1;
      end
      if (accept && ((func_i == FUNC_ADD_QUERY && !wr_q) ||
                     (func_i == FUNC_ADD_REF && !wr_r))) begin
        ovf_q <= 1'b1;
      end
      if (go) begin
        err_q <= (qcnt_q == '0) || (rcnt_q == '0) || ovf_q;
        if (qcnt_q == '0) begin
          status_q <= STATUS_NO_QUERY;
        end else if (rcnt_q == '0) begin
          status_q <= STATUS_NO_REF;
        end else if (ovf_q) begin
          status_q <= STATUS_OVERFLOW;
        end else begin
          status_q <= STATUS_OK;
        end
      end
    end
  end

  logic go_core, err_valid_q;

  assign go_core = go && (qcnt_q != '0) && (rcnt_q != '0) && !ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_valid_q <= 1'b0;
    end else if (go && !go_core) begin
      err_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      err_valid_q <= 1'b0;
    end
  end

  pncd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go_core),
    .out_taken_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_core),
    .out_valid_o (core_valid)
  );

  assign busy = busy_core || err_valid_q;

  pncd_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_query_i    (wr_q),
    .wr_ref_i      (wr_r),
    .colour_i      ({chan_l_i, chan_a_i, chan_b_i}),
    .query_count_i (qcnt_q),
    .ref_count_i   (rcnt_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mean_o        (mean)
  );

  assign out_valid_o     = core_valid || err_valid_q;
  assign mean_distance_o = err_q ? 16'h0000 : mean;
  assign status_o        = status_q;

endmodule

// ===== rtl/pncd_checker.sv =====
// ---------------------------------------------------------------------------
// pncd_checker
// port level checks for the palette distance block
// ---------------------------------------------------------------------------
`include "palette_nearest_colour_distance_macros.svh"

module pncd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] mean_distance_o,
  input logic [1:0]  status_o
);
  import pncd_pkg::*;

  `PNCD_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, out_valid_o, !in_ready_o, "input taken while result pending")
  `PNCD_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != STATUS_OK, mean_distance_o == 16'h0000, "nonzero mean on error")
  `PNCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(mean_distance_o) && $stable(status_o), "result changed while stalled")
endmodule

bind palette_nearest_colour_distance pncd_checker u_pncd_checker (.*);
